@@ design/wvm_pkg.sv @@
// Package for the wavetable voice mixer: sizing constants, op codes and
// small index helpers. Depends on nothing; imported by wavetable_voice_mixer.
package wvm_pkg;

    localparam int VOICES           = 4;
    localparam int FRACTION_BITS    = 14;
    localparam int SAMPLE_MEM_DEPTH = 65536;

    // Sample memory address width (depth is a power of two)
    localparam int ADDR_W  = $clog2(SAMPLE_MEM_DEPTH);
    localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int INT_W   = 17;
    localparam int POS_W   = FRACTION_BITS + INT_W;
    // Working position: one extra bit to hold position plus step
    localparam int WPOS_W  = POS_W + 1;
    localparam int SUM_W   = 18;

    // Shared multiplier operands: sample difference / sample, fraction / volume
    localparam int MUL_A_W = 10;
    localparam int MUL_B_W = FRACTION_BITS + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 16 + VIDX_W;

    localparam int VOL_MAX    = 64;
    localparam int MIX_SHIFT  = 8;
    localparam int MIX_OFFSET = 128;
    localparam int MIX_MAX    = 255;
    localparam int LOOP_MIN   = 2;

    localparam logic [2:0] OP_WRITE   = 3'd0;
    localparam logic [2:0] OP_SETUP   = 3'd1;
    localparam logic [2:0] OP_STEPVOL = 3'd2;
    localparam logic [2:0] OP_TRIGGER = 3'd3;
    localparam logic [2:0] OP_MIX     = 3'd4;

    // Wrap a byte address into the sample memory
    function automatic logic [ADDR_W-1:0] mem_index(input logic [SUM_W-1:0] a);
        logic [31:0] w;
        w = 32'(a);
        return w[ADDR_W-1:0];
    endfunction

    function automatic logic [VIDX_W-1:0] voice_slot(input logic [1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[VIDX_W-1:0];
    endfunction

endpackage

@@ design/wavetable_voice_mixer.sv @@
// Wavetable voice mixer top level: sample memory, voice registers and the
// per-voice mix sequencer around one shared multiplier. Depends on wvm_pkg.
//
// Usage:
// - Input channel (in_valid / in_ready) carries one command per transfer:
//   write a sample byte, set up a voice, set step and volume, trigger a voice
//   or mix. Output channel (out_valid / out_ready) carries one mixed byte and
//   the active-voice mask for every mix command, none for the others.
// - Write, setup, step/volume and trigger are taken straight from S_IDLE;
//   in_ready stays high for them.
// - A mix walks the voices one at a time through the single sample memory
//   port and the shared multiplier: a silent or stopped voice passes S_CHECK
//   and S_NEXT; a playing voice runs S_CHECK, S_FETCH0, S_FETCH1, S_INTERP,
//   S_SCALE, S_ACCUM, S_WRAP (held for each loop wrap) and S_NEXT; S_FINISH
//   then scales and clamps the sum. in_ready is low throughout.
// - The result sits in an output register. The next command is taken while
//   it waits; a following mix holds in its final step until the register
//   frees up.
// - Reset (rst_n low) clears all voice settings, flags and the output valid.
//   Sample memory contents are not cleared and must be written before use.
module wavetable_voice_mixer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        op,
    input  logic [1:0]        voice,
    input  logic [15:0]       address,
    input  logic signed [7:0] sample_value,
    input  logic [16:0]       end_offset,
    input  logic [16:0]       loop_begin,
    input  logic [16:0]       loop_length,
    input  logic [19:0]       step,
    input  logic [6:0]        volume,
    input  logic [16:0]       start_offset,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        mixed_sample,
    output logic [3:0]        active_voices
);
    import wvm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH0,
        S_FETCH1,
        S_INTERP,
        S_SCALE,
        S_ACCUM,
        S_WRAP,
        S_NEXT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    // Voice registers
    logic [15:0]       voice_base_reg   [VOICES];
    logic [INT_W-1:0]  voice_end_reg    [VOICES];
    logic [INT_W-1:0]  voice_lstart_reg [VOICES];
    logic [INT_W-1:0]  voice_llen_reg   [VOICES];
    logic [POS_W-1:0]  voice_pos_reg    [VOICES];
    logic [19:0]       voice_step_reg   [VOICES];
    logic [6:0]        voice_vol_reg    [VOICES];
    logic [VOICES-1:0] voice_active_reg;
    logic [VOICES-1:0] voice_cfg_reg;

    // Mix working registers
    logic [VIDX_W-1:0]        vidx_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [7:0]        s0_reg;
    logic signed [MUL_A_W-1:0] samp_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [WPOS_W-1:0]        pos_reg;
    logic                     out_valid_reg;
    logic [7:0]               mixed_reg;
    logic [3:0]               mask_reg;

    // Sample memory
    logic signed [7:0] sample_mem [SAMPLE_MEM_DEPTH];
    logic signed [7:0] rd_data_reg;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;

    logic in_xfer;
    logic out_free;
    logic voice_ok;
    logic [VIDX_W-1:0] in_slot;

    // Current voice view
    logic [15:0]       cur_base;
    logic [INT_W-1:0]  cur_end;
    logic [INT_W-1:0]  cur_ip;
    logic [FRACTION_BITS-1:0] cur_frac;
    logic              cur_loop;
    logic              cur_live;
    logic [WPOS_W-1:0] end_fix;
    logic [WPOS_W-1:0] loop_fix;

    // Shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    logic signed [PROD_W-1:0]  interp_shift;
    logic signed [ACC_W:0]     mix_sum;
    logic [7:0]                mix_clamped;
    logic [3:0]                mask_now;

    assign in_ready      = (state_reg == S_IDLE);
    assign in_xfer       = in_valid && in_ready;
    assign out_free      = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign mixed_sample  = mixed_reg;
    assign active_voices = mask_reg;

    assign voice_ok = (32'(voice) < 32'(VOICES));
    assign in_slot  = voice_slot(voice);

    assign cur_base = voice_base_reg[vidx_reg];
    assign cur_end  = voice_end_reg[vidx_reg];
    assign cur_ip   = voice_pos_reg[vidx_reg][POS_W-1:FRACTION_BITS];
    assign cur_frac = voice_pos_reg[vidx_reg][FRACTION_BITS-1:0];
    assign cur_loop = (voice_llen_reg[vidx_reg] > INT_W'(LOOP_MIN));
    assign cur_live = voice_active_reg[vidx_reg] && voice_cfg_reg[vidx_reg]
                      && (voice_step_reg[vidx_reg] != '0);
    assign end_fix  = {1'b0, cur_end, {FRACTION_BITS{1'b0}}};
    assign loop_fix = {1'b0, voice_llen_reg[vidx_reg], {FRACTION_BITS{1'b0}}};

    // Memory address: write address, first tap, or second tap
    always_comb
    begin
        mem_we   = 1'b0;
        mem_addr = mem_index(SUM_W'(cur_base) + SUM_W'(cur_ip));
        case (state_reg)
            S_IDLE:
            begin
                mem_addr = mem_index(SUM_W'(address));
                mem_we   = in_xfer && (op == OP_WRITE);
            end
            S_CHECK:
            begin
                mem_addr = mem_index(SUM_W'(cur_base) + SUM_W'(cur_ip));
            end
            S_FETCH0:
            begin
                // Next tap: following byte, loop start at the end, else repeat
                if (SUM_W'(cur_ip) + SUM_W'(1) < SUM_W'(cur_end))
                begin
                    mem_addr = mem_index(SUM_W'(cur_base) + SUM_W'(cur_ip) + SUM_W'(1));
                end
                else if (cur_loop)
                begin
                    mem_addr = mem_index(SUM_W'(cur_base) + SUM_W'(voice_lstart_reg[vidx_reg]));
                end
                else
                begin
                    mem_addr = mem_index(SUM_W'(cur_base) + SUM_W'(cur_ip));
                end
            end
            default:
            begin
                mem_addr = mem_index(SUM_W'(cur_base) + SUM_W'(cur_ip));
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[mem_addr] <= sample_value;
        end
        rd_data_reg <= sample_mem[mem_addr];
    end

    // Shared multiplier: tap difference times fraction, then sample times volume
    always_comb
    begin
        if (state_reg == S_SCALE)
        begin
            mul_a = samp_reg;
            mul_b = MUL_B_W'($signed({1'b0, voice_vol_reg[vidx_reg]}));
        end
        else
        begin
            mul_a = MUL_A_W'(rd_data_reg) - MUL_A_W'(s0_reg);
            mul_b = $signed({1'b0, cur_frac});
        end
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign interp_shift = prod_reg >>> FRACTION_BITS;

    // Final scale, offset and clamp
    always_comb
    begin
        mix_sum = (ACC_W+1)'(acc_reg >>> MIX_SHIFT) + (ACC_W+1)'(MIX_OFFSET);
        if (mix_sum < 0)
        begin
            mix_clamped = 8'd0;
        end
        else if (mix_sum > (ACC_W+1)'(MIX_MAX))
        begin
            mix_clamped = 8'(MIX_MAX);
        end
        else
        begin
            mix_clamped = mix_sum[7:0];
        end
        for (int i = 0; i < 4; i++)
        begin
            mask_now[i] = (i < VOICES) ? voice_active_reg[i % VOICES] : 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (op == OP_MIX))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!cur_live || (cur_ip >= cur_end))
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    state_next = S_FETCH0;
                end
            end
            S_FETCH0: state_next = S_FETCH1;
            S_FETCH1: state_next = S_INTERP;
            S_INTERP: state_next = S_SCALE;
            S_SCALE:  state_next = S_ACCUM;
            S_ACCUM:  state_next = S_WRAP;
            S_WRAP:
            begin
                if ((pos_reg < end_fix) || !cur_loop || (pos_reg < loop_fix))
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (32'(vidx_reg) == 32'(VOICES - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            voice_active_reg <= '0;
            voice_cfg_reg    <= '0;
            out_valid_reg    <= 1'b0;
            vidx_reg         <= '0;
            acc_reg          <= '0;
            for (int i = 0; i < VOICES; i++)
            begin
                voice_base_reg[i]   <= '0;
                voice_end_reg[i]    <= '0;
                voice_lstart_reg[i] <= '0;
                voice_llen_reg[i]   <= '0;
                voice_pos_reg[i]    <= '0;
                voice_step_reg[i]   <= '0;
                voice_vol_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if ((op == OP_SETUP) && voice_ok)
                        begin
                            voice_base_reg[in_slot]   <= address;
                            voice_end_reg[in_slot]    <= end_offset;
                            voice_lstart_reg[in_slot] <= loop_begin;
                            voice_llen_reg[in_slot]   <= loop_length;
                            voice_cfg_reg[in_slot]    <= 1'b1;
                        end
                        if ((op == OP_STEPVOL) && voice_ok)
                        begin
                            voice_step_reg[in_slot] <= step;
                            voice_vol_reg[in_slot]  <= (volume > 7'(VOL_MAX)) ?
                                                       7'(VOL_MAX) : volume;
                        end
                        if ((op == OP_TRIGGER) && voice_ok)
                        begin
                            voice_pos_reg[in_slot]    <= {start_offset,
                                                          {FRACTION_BITS{1'b0}}};
                            voice_active_reg[in_slot] <= 1'b1;
                        end
                        if (op == OP_MIX)
                        begin
                            vidx_reg <= '0;
                            acc_reg  <= '0;
                        end
                    end
                end
                S_CHECK:
                begin
                    // Drop a live voice that already sits at or past its end
                    if (cur_live && (cur_ip >= cur_end))
                    begin
                        voice_active_reg[vidx_reg] <= 1'b0;
                    end
                end
                S_FETCH0:
                begin
                    s0_reg <= rd_data_reg;
                end
                S_FETCH1:
                begin
                    prod_reg <= mul_p;
                end
                S_INTERP:
                begin
                    samp_reg <= MUL_A_W'(s0_reg) + interp_shift[MUL_A_W-1:0];
                end
                S_SCALE:
                begin
                    prod_reg <= mul_p;
                end
                S_ACCUM:
                begin
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                    pos_reg <= WPOS_W'(voice_pos_reg[vidx_reg])
                               + WPOS_W'(voice_step_reg[vidx_reg]);
                end
                S_WRAP:
                begin
                    if (pos_reg < end_fix)
                    begin
                        voice_pos_reg[vidx_reg] <= pos_reg[POS_W-1:0];
                    end
                    else if (!cur_loop || (pos_reg < loop_fix))
                    begin
                        // Stop: no loop, or the wrap would go below zero
                        voice_pos_reg[vidx_reg]    <= pos_reg[POS_W-1:0];
                        voice_active_reg[vidx_reg] <= 1'b0;
                    end
                    else
                    begin
                        pos_reg <= pos_reg - loop_fix;
                    end
                end
                S_NEXT:
                begin
                    if (32'(vidx_reg) != 32'(VOICES - 1))
                    begin
                        vidx_reg <= vidx_reg + VIDX_W'(1);
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        mixed_reg     <= mix_clamped;
                        mask_reg      <= mask_now;
                    end
                end
                default:
                begin
                    vidx_reg <= vidx_reg;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // A mix transfer starts the walk at the first voice with a cleared sum
    a_mix_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (op == OP_MIX)) |=>
        ((state_reg == S_CHECK) && (vidx_reg == '0) && (acc_reg == '0)))
        else $error("mix did not start at voice zero with cleared sum");

    // Leaving the final step always leaves a result in the output register
    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |=> out_valid_reg)
        else $error("finish step left no result");

    // A voice still active after wrapping sits below its end
    a_wrap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_NEXT) && ($past(state_reg) == S_WRAP)
         && voice_active_reg[vidx_reg]) |-> (pos_reg < end_fix))
        else $error("active voice left wrap at or past its end");
`endif

endmodule

@@ tb/sv/wvm_mix_checker.sv @@
// Checker for the wavetable voice mixer: watches both channels, predicts every
// mix result from the commands seen at the input and compares it with the output.
// Depends on wvm_pkg for sizing constants and op codes.
module wvm_mix_checker
    import wvm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [2:0]        op,
    input  logic [1:0]        voice,
    input  logic [15:0]       address,
    input  logic signed [7:0] sample_value,
    input  logic [16:0]       end_offset,
    input  logic [16:0]       loop_begin,
    input  logic [16:0]       loop_length,
    input  logic [19:0]       step,
    input  logic [6:0]        volume,
    input  logic [16:0]       start_offset,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [7:0]        mixed_sample,
    input  logic [3:0]        active_voices,
    output int                mismatch_count,
    output int                mixes_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] mixed;
        logic [3:0] active;
    } mix_result_t;

    logic signed [7:0] wave_mem [SAMPLE_MEM_DEPTH];
    logic [15:0]       v_base     [VOICES];
    logic [16:0]       v_end      [VOICES];
    logic [16:0]       v_loop_at  [VOICES];
    logic [16:0]       v_loop_len [VOICES];
    logic [31:0]       v_pos      [VOICES];
    logic [19:0]       v_step     [VOICES];
    logic [6:0]        v_vol      [VOICES];
    logic              v_on       [VOICES];
    logic              v_set      [VOICES];

    mix_result_t mix_due [$];
    mix_result_t want;
    int          fails = 0;

    function automatic int sample_at(input int unsigned a);
        return int'(wave_mem[a % SAMPLE_MEM_DEPTH]);
    endfunction

    // Interpolate, weight and advance every live voice; return the mixed byte and active mask
    function automatic mix_result_t run_mix();
        int                acc;
        int                s0;
        int                s1;
        int                smp;
        int                mix;
        int unsigned       ip;
        longint unsigned   pos;
        longint unsigned   end_fx;
        longint unsigned   loop_fx;
        longint unsigned   sub;
        logic              looping;
        mix_result_t       r;
        acc = 0;
        r   = '0;
        for (int i = 0; i < VOICES; i++) begin
            looping = v_loop_len[i] > 17'(LOOP_MIN);
            if (v_on[i] && v_set[i] && v_step[i] != '0) begin
                pos = v_pos[i];
                ip  = pos >> FRACTION_BITS;
                if (ip >= v_end[i]) begin
                    v_on[i] = 1'b0;
                end else begin
                    s0 = sample_at(v_base[i] + ip);
                    if (ip + 1 < v_end[i])
                        s1 = sample_at(v_base[i] + ip + 1);
                    else if (looping)
                        s1 = sample_at(v_base[i] + v_loop_at[i]);
                    else
                        s1 = s0;
                    smp = s0 + (((s1 - s0) * int'(pos[FRACTION_BITS-1:0])) >>> FRACTION_BITS);
                    acc = acc + smp * int'(v_vol[i]);

                    pos    = pos + v_step[i];
                    end_fx = v_end[i];
                    end_fx = end_fx << FRACTION_BITS;
                    if (pos >= end_fx) begin
                        if (looping) begin
                            loop_fx = v_loop_len[i];
                            loop_fx = loop_fx << FRACTION_BITS;
                            sub     = ((pos - end_fx) / loop_fx + 1) * loop_fx;
                            if (sub > pos)
                                v_on[i] = 1'b0;
                            else
                                pos = pos - sub;
                        end else begin
                            v_on[i] = 1'b0;
                        end
                    end
                    v_pos[i] = pos[31:0];
                end
            end
        end
        for (int i = 0; i < VOICES && i < 4; i++)
            r.active[i] = v_on[i];
        mix = (acc >>> MIX_SHIFT) + MIX_OFFSET;
        if (mix < 0)
            mix = 0;
        else if (mix > MIX_MAX)
            mix = MIX_MAX;
        r.mixed = 8'(mix);
        return r;
    endfunction

    function automatic void apply_cmd();
        if (op == OP_WRITE) begin
            wave_mem[address] = sample_value;
        end else if (op == OP_MIX) begin
            mix_due.push_back(run_mix());
        end else if (int'(voice) < VOICES) begin
            case (op)
                OP_SETUP: begin
                    v_base[voice]     = address;
                    v_end[voice]      = end_offset;
                    v_loop_at[voice]  = loop_begin;
                    v_loop_len[voice] = loop_length;
                    v_set[voice]      = 1'b1;
                end
                OP_STEPVOL: begin
                    v_step[voice] = step;
                    v_vol[voice]  = (volume > 7'(VOL_MAX)) ? 7'(VOL_MAX) : volume;
                end
                OP_TRIGGER: begin
                    v_pos[voice] = 32'(start_offset) << FRACTION_BITS;
                    v_on[voice]  = 1'b1;
                end
                default: ;
            endcase
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < VOICES; i++) begin
                v_base[i]     = '0;
                v_end[i]      = '0;
                v_loop_at[i]  = '0;
                v_loop_len[i] = '0;
                v_pos[i]      = '0;
                v_step[i]     = '0;
                v_vol[i]      = '0;
                v_on[i]       = 1'b0;
                v_set[i]      = 1'b0;
            end
            mix_due.delete();
        end else begin
            // results leave before the command of the same edge is applied
            if (out_valid && out_ready) begin
                if (mix_due.size() == 0) begin
                    $display("%0t: unexpected result: mixed_sample %0d active_voices %b",
                             $time, mixed_sample, active_voices);
                    fails++;
                end else begin
                    want = mix_due.pop_front();
                    if (mixed_sample !== want.mixed) begin
                        $display("%0t: mixed_sample expected %0d actual %0d",
                                 $time, want.mixed, mixed_sample);
                        fails++;
                    end
                    if (active_voices !== want.active) begin
                        $display("%0t: active_voices expected %b actual %b",
                                 $time, want.active, active_voices);
                        fails++;
                    end
                end
            end
            if (in_valid && in_ready)
                apply_cmd();
        end
        mismatch_count <= fails;
        mixes_owed     <= mix_due.size();
    end

endmodule

@@ tb/sv/tb_wavetable_voice_mixer.sv @@
// Top of the wavetable voice mixer testbench: clock, reset, command stimulus,
// output back-pressure and the verdict. Depends on wvm_pkg, wvm_mix_checker
// and the wavetable_voice_mixer RTL.
module tb_wavetable_voice_mixer;
    timeunit 1ns;
    timeprecision 1ps;
    import wvm_pkg::*;

    // Op codes the block ignores
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int LOUD_HIGH    = 16'h8000;  // block of +127 bytes
    localparam int LOUD_LOW     = 16'h8100;  // block of -128 bytes

    // One command as the sender builds it
    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  vidx;
        logic [15:0] addr;
        logic [7:0]  sval;
        logic [16:0] end_off;
        logic [16:0] loop_at;
        logic [16:0] loop_len;
        logic [19:0] stp;
        logic [6:0]  vol;
        logic [16:0] start;
    } cmd_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        op;
    logic [1:0]        voice;
    logic [15:0]       address;
    logic signed [7:0] sample_value;
    logic [16:0]       end_offset;
    logic [16:0]       loop_begin;
    logic [16:0]       loop_length;
    logic [19:0]       step;
    logic [6:0]        volume;
    logic [16:0]       start_offset;
    logic              out_valid;
    logic              out_ready;
    logic [7:0]        mixed_sample;
    logic [3:0]        active_voices;
    int                mismatch_count;
    int                mixes_owed;

    logic              gaps_on;      // random idling on both channels
    int                sent_items;   // accepted commands with a defined op
    int unsigned       cycle_count = 0;

    wavetable_voice_mixer i_dut (.*);

    wvm_mix_checker i_checker (.*);

    always #4 clk = ~clk;

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_wavetable_voice_mixer: FAIL");
            $finish;
        end
    end

    // Receiver: drop out_ready with a chance of 29 in 100 while idling is on
    always @(posedge clk)
        out_ready <= gaps_on ? ($urandom_range(0, 99) >= 29) : 1'b1;

    // Fill every field with noise, then set the op; the block must ignore
    // whatever the op does not use
    function automatic cmd_t rand_fields(input logic [2:0] code);
        cmd_t c;
        c.op       = code;
        c.vidx     = 2'($urandom);
        c.addr     = 16'($urandom);
        c.sval     = 8'($urandom);
        c.end_off  = 17'($urandom);
        c.loop_at  = 17'($urandom);
        c.loop_len = 17'($urandom);
        c.stp      = 20'($urandom);
        c.vol      = 7'($urandom);
        c.start    = 17'($urandom);
        return c;
    endfunction

    function automatic cmd_t write_cmd(input logic [15:0] a, input logic [7:0] val);
        cmd_t c;
        c      = rand_fields(OP_WRITE);
        c.addr = a;
        c.sval = val;
        return c;
    endfunction

    function automatic cmd_t setup_cmd(input logic [1:0] v, input logic [15:0] base,
                                       input logic [16:0] e, input logic [16:0] lb,
                                       input logic [16:0] ll);
        cmd_t c;
        c          = rand_fields(OP_SETUP);
        c.vidx     = v;
        c.addr     = base;
        c.end_off  = e;
        c.loop_at  = lb;
        c.loop_len = ll;
        return c;
    endfunction

    function automatic cmd_t stepvol_cmd(input logic [1:0] v, input logic [19:0] st,
                                         input logic [6:0] vl);
        cmd_t c;
        c      = rand_fields(OP_STEPVOL);
        c.vidx = v;
        c.stp  = st;
        c.vol  = vl;
        return c;
    endfunction

    function automatic cmd_t trigger_cmd(input logic [1:0] v, input logic [16:0] s);
        cmd_t c;
        c       = rand_fields(OP_TRIGGER);
        c.vidx  = v;
        c.start = s;
        return c;
    endfunction

    // Drive one command and hold it until the transfer; idle first at random
    task automatic send(input cmd_t c);
        while (gaps_on && $urandom_range(0, 99) < 29) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= c.op;
        voice        <= c.vidx;
        address      <= c.addr;
        sample_value <= c.sval;
        end_offset   <= c.end_off;
        loop_begin   <= c.loop_at;
        loop_length  <= c.loop_len;
        step         <= c.stp;
        volume       <= c.vol;
        start_offset <= c.start;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (c.op <= OP_MIX)
            sent_items++;
    endtask

    // Well-formed voice sequence: setup, step/volume, trigger, then a few
    // mixes. Most voices are short so they reach their end or loop point;
    // now and then a step is skipped to keep older settings.
    task automatic play_voice();
        logic [1:0]  v;
        int unsigned end_len;
        int unsigned lb;
        int unsigned ll;
        int unsigned st;
        int unsigned vl;
        int unsigned s;
        int unsigned pick;
        v    = 2'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 5)
            end_len = $urandom_range(0, 1);
        else if (pick < 85)
            end_len = $urandom_range(2, 64);
        else if (pick < 95)
            end_len = $urandom_range(65, 4096);
        else
            end_len = $urandom_range(4097, 131071);

        pick = $urandom_range(0, 99);
        if (pick < 35)
            ll = $urandom_range(0, LOOP_MIN);
        else if (pick < 90)
            ll = $urandom_range(LOOP_MIN + 1, (end_len > LOOP_MIN + 1) ? end_len : LOOP_MIN + 1);
        else
            ll = $urandom_range(0, 131071);
        if (end_len == 0 || $urandom_range(0, 9) == 0)
            lb = $urandom_range(0, 131071);
        else
            lb = $urandom_range(0, end_len - 1);
        if ($urandom_range(0, 9) != 0)
            send(setup_cmd(v, 16'($urandom), 17'(end_len), 17'(lb), 17'(ll)));

        pick = $urandom_range(0, 99);
        if (pick < 10)
            st = $urandom_range(1, 255);
        else if (pick < 80)
            st = $urandom_range(256, 1 << 16);
        else if (pick < 95)
            st = $urandom_range(0, 20'hFFFFF);
        else
            st = 0;
        vl = ($urandom_range(0, 9) == 0) ? $urandom_range(VOL_MAX + 1, 127)
                                         : $urandom_range(0, VOL_MAX);
        if ($urandom_range(0, 9) != 0)
            send(stepvol_cmd(v, 20'(st), 7'(vl)));

        s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, end_len);
        if ($urandom_range(0, 19) != 0)
            send(trigger_cmd(v, 17'(s)));

        repeat ($urandom_range(1, 6))
            send(rand_fields(OP_MIX));
    endtask

    // All four voices on a block of full-scale bytes at full volume: drive
    // the mix to its top or bottom code
    task automatic loud_chord();
        int unsigned base;
        base = $urandom_range(0, 1) ? LOUD_HIGH : LOUD_LOW;
        for (int v = 0; v < VOICES; v++) begin
            send(setup_cmd(2'(v), 16'(base + $urandom_range(0, 64)), 17'd64, 17'd0, 17'd0));
            send(stepvol_cmd(2'(v), 20'($urandom_range(1, 1 << FRACTION_BITS)), 7'(VOL_MAX)));
            send(trigger_cmd(2'(v), 17'($urandom_range(0, 8))));
        end
        repeat ($urandom_range(2, 4))
            send(rand_fields(OP_MIX));
    endtask

    initial begin
        cmd_t        c;
        int unsigned pick;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        op           <= OP_WRITE;
        voice        <= '0;
        address      <= '0;
        sample_value <= '0;
        end_offset   <= '0;
        loop_begin   <= '0;
        loop_length  <= '0;
        step         <= '0;
        volume       <= '0;
        start_offset <= '0;
        out_ready    <= 1'b0;
        gaps_on      <= 1'b0;
        sent_items   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Preload the whole sample memory back to back so no mix can read a
        // byte that was never written; two small blocks hold full-scale values
        for (int a = 0; a < SAMPLE_MEM_DEPTH; a++) begin
            c = write_cmd(16'(a), 8'($urandom));
            if (a >= LOUD_HIGH && a < LOUD_HIGH + 256)
                c.sval = 8'sd127;
            else if (a >= LOUD_LOW && a < LOUD_LOW + 256)
                c.sval = -8'sd128;
            send(c);
        end
        gaps_on <= 1'b1;

        // Directed: ignored ops, silent mix, address wrap at the top of memory,
        // volume saturation, end without loop, loop wrap with the loop start
        // as next sample, loop longer than the position (voice stops), an
        // unconfigured voice left active, zero step, start past the end and
        // the widest setup values
        send(rand_fields(OP_SPARE_LO));
        send(rand_fields(OP_MIX));
        send(write_cmd(16'hFFFF, 8'sd127));
        send(write_cmd(16'h0000, -8'sd128));
        send(setup_cmd(2'd0, 16'hFFFF, 17'd3, 17'd0, 17'd0));
        send(stepvol_cmd(2'd0, 20'(1 << FRACTION_BITS), 7'd127));
        send(trigger_cmd(2'd0, 17'd0));
        send(rand_fields(OP_MIX));
        send(rand_fields(OP_MIX));
        send(rand_fields(OP_MIX));
        send(setup_cmd(2'd1, 16'h0100, 17'd8, 17'd2, 17'd6));
        send(stepvol_cmd(2'd1, 20'h07FFF, 7'(VOL_MAX)));
        send(trigger_cmd(2'd1, 17'd5));
        send(setup_cmd(2'd2, 16'h1000, 17'd5, 17'd0, 17'd100));
        send(stepvol_cmd(2'd2, 20'hFFFFF, 7'd33));
        send(trigger_cmd(2'd2, 17'd0));
        send(trigger_cmd(2'd3, 17'd0));
        send(rand_fields(OP_MIX));
        send(rand_fields(OP_MIX));
        send(setup_cmd(2'd3, 16'h0000, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF));
        send(stepvol_cmd(2'd3, 20'd1, 7'd0));
        send(trigger_cmd(2'd0, 17'h1FFFF));
        send(rand_fields(OP_MIX));
        send(rand_fields(OP_SPARE_HI));
        send(rand_fields(OP_MIX));

        // Random part: mostly voice sequences, some bare mixes and raw noise
        // over every op; one stretch runs with no idling on either side
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS) begin
            gaps_on <= !(sent_items >= 300 && sent_items < 450);
            pick = $urandom_range(0, 99);
            if (pick < 60)
                play_voice();
            else if (pick < 64)
                loud_chord();
            else if (pick < 80)
                send(rand_fields(OP_MIX));
            else
                send(rand_fields(3'($urandom_range(OP_WRITE, OP_SPARE_HI))));
        end
        in_valid <= 1'b0;

        // Let the last transfer reach the checker, drain, then watch for strays
        @(posedge clk);
        while (mixes_owed != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (mismatch_count == 0 && mixes_owed == 0)
            $display("tb_wavetable_voice_mixer: PASS");
        else
            $display("tb_wavetable_voice_mixer: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
design/wvm_pkg.sv
design/wavetable_voice_mixer.sv
tb/sv/wvm_mix_checker.sv
tb/sv/tb_wavetable_voice_mixer.sv
